/* src/pcta_pkg.sv */
// Shared types and constants for the per-client token bucket admission block.
// Holds the request/result payload structs, command codes and register indexes.
// No dependencies.
package pcta_pkg;

  localparam int unsigned TIME_W   = 48;
  localparam int unsigned ADDR_W   = 64;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned OPEN_OUT_W = 22;
  localparam int unsigned BAN_OUT_W  = 11;
  localparam int unsigned OPEN_OUT_MAX = 4194303;

  localparam logic [2:0] CMD_CONNECT    = 3'd0;
  localparam logic [2:0] CMD_DISCONNECT = 3'd1;
  localparam logic [2:0] CMD_BAN        = 3'd2;
  localparam logic [2:0] CMD_QUERY      = 3'd3;
  localparam logic [2:0] CMD_INVALID    = 3'd4;
  localparam logic [2:0] CMD_CLEAR      = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_BURST     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REFILL    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_OPEN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_BAN  = 3'd5;

  localparam logic [7:0]  RST_BURST     = 8'd16;
  localparam logic [23:0] RST_REFILL    = 24'd65536;
  localparam logic [15:0] RST_MAX_OPEN  = 16'd8;
  localparam logic [31:0] RST_WINDOW    = 32'd60000;
  localparam logic [15:0] RST_THRESHOLD = 16'd50;
  localparam logic [31:0] RST_AUTO_BAN  = 32'd600000;

  typedef struct packed {
    logic [2:0]        command;
    logic [ADDR_W-1:0] addr_high;
    logic [ADDR_W-1:0] addr_low;
    logic [TIME_W-1:0] now_ms;
    logic [15:0]       ban_seconds;
  } req_t;

  typedef struct packed {
    logic                  answer;
    logic                  table_full;
    logic [OPEN_OUT_W-1:0] open_total;
    logic [BAN_OUT_W-1:0]  ban_entries;
  } rsp_t;

endpackage

/* src/per_client_token_bucket_admission_top.sv */
// Per-client token bucket admission: keyed client table, sequencer and counters.
// Depends on pcta_pkg for payload structs, command codes and register indexes.
//
// One request is taken at a time. The key search reads the client table one entry
// per cycle through its single registered read port. After the accept, a known
// command goes through the search and, where it changes an entry, the update
// states and one write-back before its result. The result is held until taken; the
// next request is accepted after that. Slots are handed out in order and never
// freed, so a fill count marks the used entries and no clearing pass is needed
// after reset. Configuration writes are taken in every cycle; write registers only
// while no request is in flight.
module per_client_token_bucket_admission_top #(
  parameter int unsigned TABLE_DEPTH     = 32,
  parameter int unsigned TOKEN_FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  pcta_pkg::req_t                     in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output pcta_pkg::rsp_t                     out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pcta_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pcta_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int unsigned IDX_W  = $clog2(TABLE_DEPTH);
  localparam int unsigned FILL_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned LVL_W  = 8 + TOKEN_FRAC_BITS;
  localparam int unsigned PROD_W = LVL_W + 24;
  localparam int unsigned OS_W   = 16 + $clog2(TABLE_DEPTH);
  localparam int unsigned TW     = pcta_pkg::TIME_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SRCH  = 4'd1;
  localparam logic [3:0] S_EXEC  = 4'd2;
  localparam logic [3:0] S_CON1  = 4'd3;
  localparam logic [3:0] S_CON2  = 4'd4;
  localparam logic [3:0] S_CON3  = 4'd5;
  localparam logic [3:0] S_INV1  = 4'd6;
  localparam logic [3:0] S_BAN   = 4'd7;
  localparam logic [3:0] S_WRITE = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  typedef struct packed {
    logic [63:0]      key_high;
    logic [63:0]      key_low;
    logic             bkt_exists;
    logic             bkt_started;
    logic [LVL_W-1:0] level;
    logic [TW-1:0]    last_ms;
    logic [15:0]      open_cnt;
    logic             win_started;
    logic [TW-1:0]    win_start;
    logic [15:0]      inv_cnt;
    logic             ban_present;
    logic [TW-1:0]    ban_until;
  } entry_t;

  function automatic entry_t ensure_bkt(entry_t e);
    entry_t r;
    r = e;
    if (!e.bkt_exists) begin
      r.bkt_exists  = 1'b1;
      r.bkt_started = 1'b0;
      r.level       = '0;
      r.last_ms     = '0;
      r.open_cnt    = '0;
      r.win_started = 1'b0;
      r.win_start   = '0;
      r.inv_cnt     = '0;
    end
    return r;
  endfunction

  // configuration
  logic [7:0]  cfg_burst_r;
  logic [23:0] cfg_refill_r;
  logic [15:0] cfg_max_open_r;
  logic [31:0] cfg_window_r;
  logic [15:0] cfg_thresh_r;
  logic [31:0] cfg_auto_ban_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_burst_r    <= pcta_pkg::RST_BURST;
      cfg_refill_r   <= pcta_pkg::RST_REFILL;
      cfg_max_open_r <= pcta_pkg::RST_MAX_OPEN;
      cfg_window_r   <= pcta_pkg::RST_WINDOW;
      cfg_thresh_r   <= pcta_pkg::RST_THRESHOLD;
      cfg_auto_ban_r <= pcta_pkg::RST_AUTO_BAN;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pcta_pkg::REG_BURST:     cfg_burst_r    <= cfg_data[7:0];
        pcta_pkg::REG_REFILL:    cfg_refill_r   <= cfg_data[23:0];
        pcta_pkg::REG_MAX_OPEN:  cfg_max_open_r <= cfg_data[15:0];
        pcta_pkg::REG_WINDOW:    cfg_window_r   <= cfg_data;
        pcta_pkg::REG_THRESHOLD: cfg_thresh_r   <= cfg_data[15:0];
        pcta_pkg::REG_AUTO_BAN:  cfg_auto_ban_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // client table
  entry_t           mem [TABLE_DEPTH];
  entry_t           rd_data_r;
  logic [IDX_W-1:0] rd_addr;
  logic             mem_we;

  // sequencer state
  logic [3:0]        state_r, state_nxt;
  pcta_pkg::req_t    req_r, req_nxt;
  entry_t            ent_r, ent_nxt;
  logic [IDX_W-1:0]  slot_r, slot_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [FILL_W-1:0] scan_r, scan_nxt;
  logic [FILL_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic              alloc_r, alloc_nxt;
  logic              answer_r, answer_nxt;
  logic              full_r, full_nxt;
  logic              upd_r, upd_nxt;
  logic [PROD_W-1:0] add_r, add_nxt;
  logic [31:0]       len_r, len_nxt;
  logic [OS_W-1:0]   open_sum_r, open_sum_nxt;
  logic [FILL_W-1:0] ban_sum_r, ban_sum_nxt;

  logic [LVL_W-1:0] cap;
  logic [LVL_W-1:0] one_tok;
  assign cap     = LVL_W'(cfg_burst_r) << TOKEN_FRAC_BITS;
  assign one_tok = LVL_W'(1) << TOKEN_FRAC_BITS;

  assign rd_addr = scan_r[IDX_W-1:0];
  assign mem_we  = (state_r == S_WRITE);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[slot_r] <= ent_r;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    entry_t          e;
    logic [TW-1:0]   el;
    logic [PROD_W:0] lvl_sum;
    logic [TW:0]     dl_sum;
    logic            restart;

    state_nxt    = state_r;
    req_nxt      = req_r;
    ent_nxt      = ent_r;
    slot_nxt     = slot_r;
    fill_nxt     = fill_r;
    scan_nxt     = scan_r;
    cmp_idx_nxt  = cmp_idx_r;
    cmp_vld_nxt  = 1'b0;
    alloc_nxt    = alloc_r;
    answer_nxt   = answer_r;
    full_nxt     = full_r;
    upd_nxt      = upd_r;
    add_nxt      = add_r;
    len_nxt      = len_r;
    open_sum_nxt = open_sum_r;
    ban_sum_nxt  = ban_sum_r;
    e            = ent_r;
    el           = '0;
    lvl_sum      = '0;
    dl_sum       = '0;
    restart      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt    = in_data;
          answer_nxt = 1'b0;
          full_nxt   = 1'b0;
          alloc_nxt  = 1'b0;
          scan_nxt   = '0;
          if (in_data.command > pcta_pkg::CMD_CLEAR) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SRCH;
          end
        end
      end

      S_SRCH: begin
        // one read issued per cycle; the compare works on the registered read data
        if (scan_r < fill_r) begin
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = scan_r;
          scan_nxt    = scan_r + FILL_W'(1);
        end
        if (cmp_vld_r && rd_data_r.key_high == req_r.addr_high
            && rd_data_r.key_low == req_r.addr_low) begin
          cmp_vld_nxt = 1'b0;
          ent_nxt     = rd_data_r;
          slot_nxt    = cmp_idx_r[IDX_W-1:0];
          state_nxt   = S_EXEC;
        end else if (!cmp_vld_r && scan_r >= fill_r) begin
          if (req_r.command == pcta_pkg::CMD_CONNECT || req_r.command == pcta_pkg::CMD_BAN
              || req_r.command == pcta_pkg::CMD_INVALID) begin
            if (fill_r == FILL_W'(TABLE_DEPTH)) begin
              full_nxt  = 1'b1;
              state_nxt = S_DONE;
            end else begin
              e             = ent_r;
              e.key_high    = req_r.addr_high;
              e.key_low     = req_r.addr_low;
              e.bkt_exists  = 1'b0;
              e.bkt_started = 1'b0;
              e.win_started = 1'b0;
              e.ban_present = 1'b0;
              ent_nxt       = e;
              slot_nxt      = fill_r[IDX_W-1:0];
              alloc_nxt     = 1'b1;
              state_nxt     = S_EXEC;
            end
          end else begin
            state_nxt = S_DONE;
          end
        end
      end

      S_EXEC: begin
        unique case (req_r.command)
          pcta_pkg::CMD_CONNECT: begin
            if (ent_r.ban_present && req_r.now_ms < ent_r.ban_until) begin
              state_nxt = S_DONE;
            end else begin
              if (ent_r.ban_present) begin
                e.ban_present = 1'b0;
                ban_sum_nxt   = ban_sum_r - FILL_W'(1);
              end
              e = ensure_bkt(e);
              if (!e.bkt_started) begin
                e.bkt_started = 1'b1;
                e.level       = cap;
                e.last_ms     = req_r.now_ms;
              end
              ent_nxt   = e;
              state_nxt = S_CON1;
            end
          end
          pcta_pkg::CMD_DISCONNECT: begin
            if (ent_r.bkt_exists && ent_r.open_cnt != '0) begin
              e.open_cnt   = ent_r.open_cnt - 16'd1;
              open_sum_nxt = open_sum_r - OS_W'(1);
            end
            ent_nxt   = e;
            state_nxt = S_WRITE;
          end
          pcta_pkg::CMD_BAN: begin
            len_nxt   = 32'(req_r.ban_seconds) * 32'd1000;
            state_nxt = S_BAN;
          end
          pcta_pkg::CMD_QUERY: begin
            answer_nxt = ent_r.ban_present && (req_r.now_ms < ent_r.ban_until);
            state_nxt  = S_DONE;
          end
          pcta_pkg::CMD_INVALID: begin
            e  = ensure_bkt(ent_r);
            el = req_r.now_ms - e.win_start;
            restart = !e.win_started
                      || (req_r.now_ms > e.win_start && el > TW'(cfg_window_r));
            if (restart) begin
              e.win_started = 1'b1;
              e.win_start   = req_r.now_ms;
              e.inv_cnt     = '0;
            end
            if (e.inv_cnt != 16'hFFFF) begin
              e.inv_cnt = e.inv_cnt + 16'd1;
            end
            ent_nxt   = e;
            state_nxt = S_INV1;
          end
          pcta_pkg::CMD_CLEAR: begin
            if (ent_r.bkt_exists) begin
              e.inv_cnt = '0;
            end
            ent_nxt   = e;
            state_nxt = S_WRITE;
          end
          default: state_nxt = S_DONE;
        endcase
      end

      S_CON1: begin
        // refill amount: capped elapsed time keeps the product narrow
        upd_nxt = req_r.now_ms > ent_r.last_ms;
        el      = req_r.now_ms - ent_r.last_ms;
        if (cfg_refill_r != '0 && el > TW'(cap)) begin
          add_nxt = PROD_W'(cap);
        end else begin
          add_nxt = PROD_W'(el[LVL_W-1:0]) * PROD_W'(cfg_refill_r);
        end
        state_nxt = S_CON2;
      end

      S_CON2: begin
        if (upd_r) begin
          lvl_sum = (PROD_W + 1)'(ent_r.level) + (PROD_W + 1)'(add_r);
          if (lvl_sum > (PROD_W + 1)'(cap)) begin
            e.level = cap;
          end else begin
            e.level = lvl_sum[LVL_W-1:0];
          end
          e.last_ms = req_r.now_ms;
        end
        ent_nxt   = e;
        state_nxt = S_CON3;
      end

      S_CON3: begin
        if (ent_r.level >= one_tok && ent_r.open_cnt < cfg_max_open_r) begin
          e.level      = ent_r.level - one_tok;
          e.open_cnt   = ent_r.open_cnt + 16'd1;
          open_sum_nxt = open_sum_r + OS_W'(1);
          answer_nxt   = 1'b1;
        end
        ent_nxt   = e;
        state_nxt = S_WRITE;
      end

      S_INV1: begin
        if (ent_r.inv_cnt >= cfg_thresh_r) begin
          e.inv_cnt  = '0;
          answer_nxt = 1'b1;
          len_nxt    = cfg_auto_ban_r;
          ent_nxt    = e;
          state_nxt  = S_BAN;
        end else begin
          state_nxt = S_WRITE;
        end
      end

      S_BAN: begin
        // saturate the deadline at the top of the time range
        dl_sum = (TW + 1)'(req_r.now_ms) + (TW + 1)'(len_r);
        e.ban_until = dl_sum[TW] ? {TW{1'b1}} : dl_sum[TW-1:0];
        if (!ent_r.ban_present) begin
          e.ban_present = 1'b1;
          ban_sum_nxt   = ban_sum_r + FILL_W'(1);
        end
        ent_nxt   = e;
        state_nxt = S_WRITE;
      end

      S_WRITE: begin
        if (alloc_r) begin
          fill_nxt = fill_r + FILL_W'(1);
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      fill_r     <= '0;
      scan_r     <= '0;
      cmp_vld_r  <= 1'b0;
      alloc_r    <= 1'b0;
      answer_r   <= 1'b0;
      full_r     <= 1'b0;
      upd_r      <= 1'b0;
      open_sum_r <= '0;
      ban_sum_r  <= '0;
    end else begin
      state_r    <= state_nxt;
      fill_r     <= fill_nxt;
      scan_r     <= scan_nxt;
      cmp_vld_r  <= cmp_vld_nxt;
      alloc_r    <= alloc_nxt;
      answer_r   <= answer_nxt;
      full_r     <= full_nxt;
      upd_r      <= upd_nxt;
      open_sum_r <= open_sum_nxt;
      ban_sum_r  <= ban_sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    ent_r     <= ent_nxt;
    slot_r    <= slot_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    add_r     <= add_nxt;
    len_r     <= len_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_DONE);

  always_comb begin
    out_data.answer     = answer_r;
    out_data.table_full = full_r;
    if (32'(open_sum_r) > 32'(pcta_pkg::OPEN_OUT_MAX)) begin
      out_data.open_total = pcta_pkg::OPEN_OUT_W'(pcta_pkg::OPEN_OUT_MAX);
    end else begin
      out_data.open_total = pcta_pkg::OPEN_OUT_W'(open_sum_r);
    end
    out_data.ban_entries = pcta_pkg::BAN_OUT_W'(ban_sum_r);
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  // a new slot is counted only at its write-back, the state that follows its ban
  a_ban_le_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_WRITE) |-> (ban_sum_r <= fill_r))
    else $error("more ban entries than stored clients");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && full_r) |-> (fill_r == FILL_W'(TABLE_DEPTH)))
    else $error("table full flagged with free slots");

  a_full_no_answer: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && full_r) |-> !answer_r)
    else $error("refused request reports an answer");

  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r != $past(fill_r)) |-> ($past(state_r) == S_WRITE && $past(alloc_r)))
    else $error("fill count moved outside an allocating write-back");

endmodule
